/* src/labeled_graph_dfs_engine_defines.svh */
// Assertion macros for the checker module.
`ifndef LABELED_GRAPH_DFS_ENGINE_DEFINES_SVH
`define LABELED_GRAPH_DFS_ENGINE_DEFINES_SVH

// Checked only outside reset.
`define LDFS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("ldfs check failed");

// Checked at every edge, reset included.
`define LDFS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("ldfs check failed");

`endif

/* src/ldfs_pkg.sv */
package ldfs_pkg;

  localparam int DEF_MAX_VERTICES = 32;
  localparam int DEF_MAX_EDGES    = 128;
  localparam int DEF_LABEL_BITS   = 8;
  localparam int VFIELD_BITS      = 5;
  localparam int LFIELD_BITS      = 8;
  localparam int CMP_BITS         = 8;
  localparam logic [5:0] VERTEX_LIMIT_RESET = 6'd32;

  typedef enum logic [1:0] {
    FN_ADD_VERTEX = 2'd0,
    FN_ADD_EDGE   = 2'd1,
    FN_WALK       = 2'd2,
    FN_NONE       = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_UNKNOWN   = 2'd2,
    ST_DUPLICATE = 2'd3
  } status_t;

  localparam logic REG_VERTEX_LIMIT = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SCAN_WAIT,
    S_WFETCH,
    S_WPOP,
    S_WEDGE
  } state_t;

endpackage

/* src/ldfs_ram.sv */
module ldfs_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/labeled_graph_dfs_engine.sv */
// Labeled-graph depth-first walk engine. Requests arrive on the s_ stream, one at a time;
// results leave on the m_ stream through an output register, with m_tlast on the final
// result of each request. The duplicate scan of an edge request walks the source vertex's
// edge list in the edge memory, one registered read per entry (S_SCAN, S_SCAN_WAIT).
// A walk reads the edge lists of the visited vertices and pops the stack memory the same
// way (S_WFETCH, S_WEDGE, S_WPOP). No clearing pass is needed after reset.
module labeled_graph_dfs_engine #(
  parameter int MAX_VERTICES = ldfs_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = ldfs_pkg::DEF_MAX_EDGES,
  parameter int LABEL_BITS   = ldfs_pkg::DEF_LABEL_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // func[1:0], from_vertex[6:2], to_vertex[11:7], edge_label[19:12], zero fill
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], vertex_out[6:2], zero fill
  output logic [7:0]  m_tdata,
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ldfs_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int SAW = $clog2(MAX_VERTICES);
  localparam int ENW = LABEL_BITS + VW + EW;

  state_t state, state_next;
  logic [1:0] fn, fn_next;
  logic [VFIELD_BITS-1:0] frm, frm_next, tov, tov_next;
  logic [LABEL_BITS-1:0] lab, lab_next;
  logic [EW-1:0] p, p_next, cur, cur_next;
  logic [CW-1:0] sp, sp_next, vcount, vcount_next;
  logic [EW-1:0] ecount, ecount_next;
  logic [MAX_VERTICES-1:0] visited, visited_next;
  logic [VW-1:0] pend, pend_next;
  logic [EW-1:0] heads [MAX_VERTICES];
  logic [5:0] vlimit;

  logic head_we;
  logic [VW-1:0] head_widx, head_ridx;
  logic [EW-1:0] head_wdata, head_rd;

  logic e_we, e_re;
  logic [EAW-1:0] e_raddr;
  logic [ENW-1:0] e_wdata, e_rdata;
  logic [LABEL_BITS-1:0] e_lab;
  logic [VW-1:0] e_tgt;
  logic [EW-1:0] e_link;

  logic s_we, s_re;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [EW-1:0] s_rdata;

  logic out_load, out_last;
  status_t out_status;
  logic [VFIELD_BITS-1:0] out_vertex;

  logic can_emit, from_ok, to_ok, vfull, efull, lab_hit, dup_hit, push_ok, stack_full;
  logic [VW-1:0] fidx;
  logic [CMP_BITS-1:0] lim;
  logic [EW-1:0] p_dec, cur_dec;
  logic [CW-1:0] sp_dec;
  logic [15:0] lab_wide;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_VERTEX_LIMIT) ? 32'(vlimit) : '0;
  assign s_tready = (state == S_IDLE);
  assign lab_wide = 16'(s_tdata[19:12]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vlimit <= VERTEX_LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_VERTEX_LIMIT) begin
      vlimit <= pwdata[5:0];
    end
  end

  ldfs_ram #(.W(ENW), .DEPTH(MAX_EDGES)) u_edge_mem (
    .clk   (clk),
    .we    (e_we),
    .waddr (ecount[EAW-1:0]),
    .wdata (e_wdata),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  ldfs_ram #(.W(EW), .DEPTH(MAX_VERTICES)) u_stack_mem (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (e_link),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign e_wdata = {head_rd, VW'(tov), lab};
  assign {e_link, e_tgt, e_lab} = e_rdata;

  assign fidx       = VW'(frm);
  assign lim        = (CMP_BITS'(vlimit) < CMP_BITS'(MAX_VERTICES)) ?
                      CMP_BITS'(vlimit) : CMP_BITS'(MAX_VERTICES);
  assign vfull      = CMP_BITS'(vcount) >= lim;
  assign from_ok    = CMP_BITS'(frm) < CMP_BITS'(vcount);
  assign to_ok      = CMP_BITS'(tov) < CMP_BITS'(vcount);
  assign efull      = ecount == EW'(MAX_EDGES);
  assign can_emit   = !m_tvalid || m_tready;
  assign lab_hit    = e_lab == lab;
  assign dup_hit    = lab_hit && (e_tgt == VW'(tov));
  assign stack_full = sp == CW'(MAX_VERTICES);
  assign push_ok    = lab_hit && !visited[e_tgt] && !stack_full;
  assign head_ridx  = (state == S_WEDGE) ? e_tgt : fidx;
  assign head_rd    = heads[head_ridx];
  assign p_dec      = p - EW'(1);
  assign cur_dec    = cur - EW'(1);
  assign sp_dec     = sp - CW'(1);
  assign e_raddr    = (state == S_SCAN) ? p_dec[EAW-1:0] : cur_dec[EAW-1:0];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (fn)
          FN_ADD_VERTEX: if (can_emit) state_next = S_IDLE;
          FN_ADD_EDGE: begin
            if (from_ok && to_ok) state_next = S_SCAN;
            else if (can_emit) state_next = S_IDLE;
          end
          FN_WALK: begin
            if (from_ok) state_next = S_WFETCH;
            else if (can_emit) state_next = S_IDLE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (p != '0) state_next = S_SCAN_WAIT;
        else if (can_emit) state_next = S_IDLE;
      end
      S_SCAN_WAIT: begin
        if (!dup_hit) state_next = S_SCAN;
        else if (can_emit) state_next = S_IDLE;
      end
      S_WFETCH: begin
        if (cur != '0) state_next = S_WEDGE;
        else if (sp != CW'(1)) state_next = S_WPOP;
        else if (can_emit) state_next = S_IDLE;
      end
      S_WPOP: state_next = S_WFETCH;
      S_WEDGE: begin
        if (!push_ok || can_emit) state_next = S_WFETCH;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    fn_next = fn;
    frm_next = frm;
    tov_next = tov;
    lab_next = lab;
    p_next = p;
    cur_next = cur;
    sp_next = sp;
    vcount_next = vcount;
    ecount_next = ecount;
    visited_next = visited;
    pend_next = pend;
    head_we = 1'b0;
    head_widx = fidx;
    head_wdata = ecount + EW'(1);
    e_we = 1'b0;
    e_re = 1'b0;
    s_we = 1'b0;
    s_re = 1'b0;
    s_waddr = sp_dec[SAW-1:0];
    s_raddr = SAW'(sp - CW'(2));
    out_load = 1'b0;
    out_status = ST_OK;
    out_vertex = '0;
    out_last = 1'b1;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          fn_next  = s_tdata[1:0];
          frm_next = s_tdata[6:2];
          tov_next = s_tdata[11:7];
          lab_next = lab_wide[LABEL_BITS-1:0];
        end
      end
      S_DECODE: begin
        case (fn)
          FN_ADD_VERTEX: begin
            if (can_emit) begin
              out_load = 1'b1;
              if (vfull) begin
                out_status = ST_FULL;
              end else begin
                out_vertex  = VFIELD_BITS'(vcount);
                vcount_next = vcount + CW'(1);
              end
            end
          end
          FN_ADD_EDGE: begin
            if (from_ok && to_ok) begin
              p_next = head_rd;
            end else if (can_emit) begin
              out_load   = 1'b1;
              out_status = ST_UNKNOWN;
            end
          end
          FN_WALK: begin
            if (from_ok) begin
              visited_next = '0;
              visited_next[fidx] = 1'b1;
              pend_next = fidx;
              cur_next  = head_rd;
              sp_next   = CW'(1);
            end else if (can_emit) begin
              out_load   = 1'b1;
              out_status = ST_UNKNOWN;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (p != '0) begin
          e_re = 1'b1;
        end else if (can_emit) begin
          out_load = 1'b1;
          if (efull) begin
            out_status = ST_FULL;
          end else begin
            e_we        = 1'b1;
            head_we     = 1'b1;
            ecount_next = ecount + EW'(1);
          end
        end
      end
      S_SCAN_WAIT: begin
        if (!dup_hit) begin
          p_next = e_link;
        end else if (can_emit) begin
          out_load   = 1'b1;
          out_status = ST_DUPLICATE;
        end
      end
      S_WFETCH: begin
        if (cur != '0) begin
          e_re = 1'b1;
        end else if (sp != CW'(1)) begin
          sp_next = sp_dec;
          s_re    = 1'b1;
        end else if (can_emit) begin
          out_load   = 1'b1;
          out_vertex = VFIELD_BITS'(pend);
        end
      end
      S_WPOP: begin
        cur_next = s_rdata;
      end
      S_WEDGE: begin
        if (!push_ok) begin
          cur_next = e_link;
        end else if (can_emit) begin
          out_load   = 1'b1;
          out_vertex = VFIELD_BITS'(pend);
          out_last   = 1'b0;
          visited_next[e_tgt] = 1'b1;
          s_we      = 1'b1;
          cur_next  = head_rd;
          sp_next   = sp + CW'(1);
          pend_next = e_tgt;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      vcount <= '0;
      ecount <= '0;
      sp     <= '0;
    end else begin
      state  <= state_next;
      vcount <= vcount_next;
      ecount <= ecount_next;
      sp     <= sp_next;
    end
  end

  always_ff @(posedge clk) begin
    fn      <= fn_next;
    frm     <= frm_next;
    tov     <= tov_next;
    lab     <= lab_next;
    p       <= p_next;
    cur     <= cur_next;
    pend    <= pend_next;
    visited <= visited_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_VERTICES; i++) heads[i] <= '0;
    end else if (head_we) begin
      heads[head_widx] <= head_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, out_vertex, out_status};
      m_tlast <= out_last;
    end
  end

endmodule

/* src/ldfs_checker.sv */
`include "labeled_graph_dfs_engine_defines.svh"

module ldfs_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);
  import ldfs_pkg::*;

  `LDFS_ASSERT_ALWAYS(a_reset_quiet, rst |=> !m_tvalid)
  `LDFS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  `LDFS_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready)
  `LDFS_ASSERT(a_error_is_last, m_tvalid && m_tdata[1:0] != ST_OK |-> m_tlast)
  `LDFS_ASSERT(a_error_no_vertex, m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[6:2] == 5'd0)

endmodule

bind labeled_graph_dfs_engine ldfs_checker u_ldfs_checker (.*);

/* verif/labeled_graph_dfs_engine_tb.sv */
`timescale 1ns / 100ps

module labeled_graph_dfs_engine_tb;
  import ldfs_pkg::*;

  localparam int NV = DEF_MAX_VERTICES;
  localparam int NE = DEF_MAX_EDGES;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    status_t    status;
    logic [4:0] vertex;
    logic       last;
  } graph_result_t;

  class graph_scoreboard;
    graph_result_t pending[$];
    int errors;
    int limit;
    int vcount;
    int ecount;
    int head[NV];
    int elabel[NE];
    int etarget[NE];
    int elink[NE];
    bit seen[NV];
    int stk_link[NV];

    function new();
      errors = 0;
      limit = VERTEX_LIMIT_RESET;
      vcount = 0;
      ecount = 0;
      foreach (head[i]) head[i] = 0;
    endfunction

    function void set_limit(int v);
      limit = v & 63;
    endfunction

    function void push(status_t s, int v, bit l);
      graph_result_t r;
      r.status = s;
      r.vertex = v[4:0];
      r.last = l;
      pending.push_back(r);
    endfunction

    function void note_request(func_t f, int fr, int to, int lab);
      int lim;
      int p;
      int sp;
      int w;
      case (f)
        FN_ADD_VERTEX: begin
          lim = (limit < NV) ? limit : NV;
          if (vcount >= lim) begin
            push(ST_FULL, 0, 1);
          end else begin
            push(ST_OK, vcount, 1);
            vcount++;
          end
        end
        FN_ADD_EDGE: begin
          if (fr >= vcount || to >= vcount) begin
            push(ST_UNKNOWN, 0, 1);
            return;
          end
          p = head[fr];
          while (p != 0) begin
            if (etarget[p-1] == to && elabel[p-1] == lab) begin
              push(ST_DUPLICATE, 0, 1);
              return;
            end
            p = elink[p-1];
          end
          if (ecount >= NE) begin
            push(ST_FULL, 0, 1);
            return;
          end
          elabel[ecount] = lab;
          etarget[ecount] = to;
          elink[ecount] = head[fr];
          head[fr] = ecount + 1;
          ecount++;
          push(ST_OK, 0, 1);
        end
        FN_WALK: begin
          if (fr >= vcount) begin
            push(ST_UNKNOWN, 0, 1);
            return;
          end
          foreach (seen[i]) seen[i] = 0;
          seen[fr] = 1;
          push(ST_OK, fr, 0);
          stk_link[0] = head[fr];
          sp = 1;
          while (sp > 0) begin
            p = stk_link[sp-1];
            while (p != 0 && elabel[p-1] != lab) p = elink[p-1];
            if (p == 0) begin
              sp--;
            end else begin
              stk_link[sp-1] = elink[p-1];
              w = etarget[p-1];
              if (!seen[w] && sp < NV) begin
                seen[w] = 1;
                push(ST_OK, w, 0);
                stk_link[sp] = head[w];
                sp++;
              end
            end
          end
          pending[$].last = 1;
        end
        default: ;
      endcase
    endfunction

    function void check_result(status_t s, logic [4:0] v, logic l);
      graph_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d vertex=%0d last=%0b", $time, s, v, l);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.status != s || e.vertex != v || e.last != l) begin
        $display("%0t: mismatch expected status=%0d vertex=%0d last=%0b, got %0d %0d %0b",
                 $time, e.status, e.vertex, e.last, s, v, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  graph_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  int cycles = 0;

  labeled_graph_dfs_engine uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(status_t'(m_tdata[1:0]), m_tdata[6:2], m_tlast);
    m_tready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send_request(func_t f, int fr, int to, int lab);
    s_tvalid <= 1;
    s_tdata <= {4'd0, lab[7:0], to[4:0], fr[4:0], f};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    sb.note_request(f, fr, to, lab);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_limit(int v);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {1'b0, REG_VERTEX_LIMIT, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.set_limit(v);
    @(posedge clk);
  endtask

  task automatic random_request();
    int r;
    int lab;
    r = $urandom_range(99);
    lab = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(3);
    if (r < 10)
      send_request(FN_ADD_VERTEX, $urandom_range(31), $urandom_range(31), $urandom_range(255));
    else if (r < 58)
      send_request(FN_ADD_EDGE, $urandom_range(31), $urandom_range(31), lab);
    else if (r < 95)
      send_request(FN_WALK, $urandom_range(31), $urandom_range(31), lab);
    else
      send_request(FN_NONE, $urandom_range(31), $urandom_range(31), $urandom_range(255));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_limit(1);
    send_request(FN_WALK, 0, 0, 0);
    send_request(FN_ADD_VERTEX, 31, 31, 255);
    send_request(FN_ADD_VERTEX, 0, 0, 0);
    send_request(FN_ADD_EDGE, 0, 1, 5);
    send_request(FN_ADD_EDGE, 0, 0, 255);
    send_request(FN_ADD_EDGE, 0, 0, 255);
    send_request(FN_WALK, 1, 0, 255);
    send_request(FN_WALK, 0, 0, 255);
    send_request(FN_NONE, 31, 31, 255);
    drain();
    write_limit(32);
    for (int i = 0; i < 4; i++) send_request(FN_ADD_VERTEX, 0, 0, 0);
    send_request(FN_ADD_EDGE, 0, 1, 1);
    send_request(FN_ADD_EDGE, 0, 2, 1);
    send_request(FN_ADD_EDGE, 1, 3, 1);
    send_request(FN_ADD_EDGE, 3, 0, 1);
    send_request(FN_ADD_EDGE, 2, 4, 1);
    send_request(FN_ADD_EDGE, 1, 2, 0);
    send_request(FN_WALK, 0, 0, 1);
    send_request(FN_WALK, 1, 0, 0);
    send_request(FN_WALK, 31, 0, 1);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; write_limit(32); end
        1: begin send_idle = 48; recv_stall = 0; write_limit(20); end
        2: begin send_idle = 0; recv_stall = 48; write_limit(32); end
        default: begin send_idle = 23; recv_stall = 23; write_limit(1); end
      endcase
      for (int i = 0; i < 68; i++) begin
        if (ph == 1 && i == 30) begin
          s_tvalid <= 0;
          @(posedge clk);
          while (sb.pending.size() != 0) @(posedge clk);
        end
        random_request();
      end
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
